@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Check that cons holds whenever ante holds.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/mitc_pkg.sv @@
package mitc_pkg;

   localparam int EL_W   = 32;
   localparam int CMAG_W = 96;
   localparam int COF_W  = 97;
   localparam int DMAG_W = 130;
   localparam int DET_W  = 131;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COF,
      ST_DET,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Magnitude of a signed element; the most negative value maps to 2^31.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Index i of the three rows (or columns) left after dropping x.
   function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] x);
      return i + {1'b0, (i >= x)};
   endfunction

   // Column pick j of permutation p.
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] j);
      logic [5:0] t;
      unique case (p)
         3'd0: t = 6'b10_01_00;
         3'd1: t = 6'b01_10_00;
         3'd2: t = 6'b10_00_01;
         3'd3: t = 6'b00_10_01;
         3'd4: t = 6'b01_00_10;
         3'd5: t = 6'b00_01_10;
         default: t = 6'b10_01_00;
      endcase
      return t[j*2 +: 2];
   endfunction

   function automatic logic perm_odd(input logic [2:0] p);
      logic [5:0] t;
      t = 6'b100110;
      return (p < 3'd6) ? t[p] : 1'b0;
   endfunction

endpackage

@@ rtl/mitc_div.sv @@
module mitc_div #(
   parameter int NUM_W = 129,
   parameter int DEN_W = 130
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       num,
   input  logic [DEN_W-1:0]       den,
   output logic [NUM_W-1:0]       quot,
   output mitc_pkg::div_status_type sts
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff;
   logic             running_ff, done_ff;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   // One restoring step: shift in the next numerator bit, subtract if it fits.
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - {1'b0, den};
      ge     = (trial >= {1'b0, den});
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else if (start) begin
         running_ff <= 1'b1;
         done_ff    <= 1'b0;
         cnt_ff     <= CW'(NUM_W);
      end else if (running_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            running_ff <= 1'b0;
            done_ff    <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
      end else if (running_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quot     = quo_ff;
   assign sts.busy = running_ff;
   assign sts.done = done_ff;

endmodule

@@ rtl/matrix_inverse_transpose_4x4_unit.sv @@
// Inverse transpose of a 4x4 signed fixed-point matrix by cofactors.
// Input channel req_: one element per transaction, row-major, sixteen per
// matrix. req_stall is low only while the block loads; after the sixteenth
// element it stays high until the whole result run has been handed over
// to the output register.
// Output channel rsp_: sixteen elements of the inverse transpose,
// row-major, rsp_last on the sixteenth; a zero determinant gives a single
// transaction with rsp_singular and rsp_last set. rsp_saturated marks
// clipped elements.
// Steps per matrix: load sixteen elements, build the sixteen cofactors
// (each a sum of triple products on the one 32x32 multiplier), form the
// determinant, then divide each cofactor in the bit-serial divider.
// A stalled result holds in the output register while the next division
// runs; a finished element waits until the register is free. The last
// result may wait while the next matrix loads. Reset returns the block to
// loading at element zero.
`include "assert_macros.svh"

module matrix_inverse_transpose_4x4_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value_out,
   output logic               rsp_singular,
   output logic               rsp_saturated,
   output logic               rsp_last
);

   localparam int SH    = 2 * FRAC_BITS + 1;
   localparam int NUM_W = mitc_pkg::CMAG_W + SH;

   mitc_pkg::state_type state_ff, state_in;
   logic [2:0] ph_ff, ph_in;
   logic [2:0] term_ff, term_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic       req_accept, out_free, out_load, div_start;

   logic [31:0]  store_ff [16];
   logic [31:0]  ea_ff, eb_ff, ec_ff, hi_ff;
   logic [63:0]  mp_ff;
   logic [127:0] t_ff;
   logic [mitc_pkg::COF_W-1:0]  acc_ff, acc_new;
   logic [mitc_pkg::COF_W-1:0]  cof_ff [16];
   logic [mitc_pkg::CMAG_W-1:0] cm_ff;
   logic                        cneg_ff, dneg_ff;
   logic [mitc_pkg::DET_W-1:0]  det_ff, det_abs;
   logic [mitc_pkg::DMAG_W-1:0] dmag_ff;

   logic [3:0]  rd_addr;
   logic [31:0] rd_data;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [1:0]  row, col;
   logic        term_neg;
   logic [mitc_pkg::COF_W-1:0] cof_rd, cof_abs;

   logic [NUM_W-1:0] div_num, div_quot, q_half;
   logic [NUM_W:0]   q_inc;
   logic             res_neg, res_big, res_sat;
   logic [31:0]      res_val;
   mitc_pkg::div_status_type div_sts;

   logic [31:0] rsp_value_ff;
   logic        rsp_valid_ff, rsp_singular_ff, rsp_saturated_ff, rsp_last_ff;

   assign row        = idx_ff[3:2];
   assign col        = idx_ff[1:0];
   assign req_accept = req_valid && (state_ff == mitc_pkg::ST_LOAD);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Element read port: one address per cycle.
   always_comb begin
      rd_addr = idx_ff;
      if (state_ff == mitc_pkg::ST_COF) begin
         unique case (ph_ff)
            3'd0: rd_addr = {mitc_pkg::skip_idx(2'd0, row),
                             mitc_pkg::skip_idx(mitc_pkg::perm_col(term_ff, 2'd0), col)};
            3'd1: rd_addr = {mitc_pkg::skip_idx(2'd1, row),
                             mitc_pkg::skip_idx(mitc_pkg::perm_col(term_ff, 2'd1), col)};
            default: rd_addr = {mitc_pkg::skip_idx(2'd2, row),
                                mitc_pkg::skip_idx(mitc_pkg::perm_col(term_ff, 2'd2), col)};
         endcase
      end
   end
   assign rd_data = store_ff[rd_addr];

   // Shared multiplier operand select.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      priority if (state_ff == mitc_pkg::ST_COF && ph_ff == 3'd2) begin
         mul_a = mitc_pkg::mag32(ea_ff);
         mul_b = mitc_pkg::mag32(eb_ff);
      end else if (state_ff == mitc_pkg::ST_COF && ph_ff == 3'd3) begin
         mul_a = mp_ff[31:0];
         mul_b = mitc_pkg::mag32(ec_ff);
      end else if (state_ff == mitc_pkg::ST_COF && ph_ff == 3'd4) begin
         mul_a = hi_ff;
         mul_b = mitc_pkg::mag32(ec_ff);
      end else if (state_ff == mitc_pkg::ST_DET && ph_ff == 3'd1) begin
         mul_a = cm_ff[31:0];
         mul_b = mitc_pkg::mag32(ea_ff);
      end else if (state_ff == mitc_pkg::ST_DET && ph_ff == 3'd2) begin
         mul_a = cm_ff[63:32];
         mul_b = mitc_pkg::mag32(ea_ff);
      end else if (state_ff == mitc_pkg::ST_DET && ph_ff == 3'd3) begin
         mul_a = cm_ff[95:64];
         mul_b = mitc_pkg::mag32(ea_ff);
      end else begin
         mul_a = '0;
         mul_b = '0;
      end
   end
   assign mul_p = mul_a * mul_b;

   // Fold the permutation parity, the operand signs and the cofactor checkerboard sign into each term.
   assign term_neg = mitc_pkg::perm_odd(term_ff) ^ ea_ff[31] ^ eb_ff[31] ^ ec_ff[31]
                     ^ row[0] ^ col[0];
   assign acc_new  = term_neg ? (acc_ff - {1'b0, t_ff[95:0]})
                              : (acc_ff + {1'b0, t_ff[95:0]});

   assign cof_rd  = cof_ff[idx_ff];
   assign cof_abs = cof_rd[mitc_pkg::COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;
   assign det_abs = det_ff[mitc_pkg::DET_W-1] ? (~det_ff + 1'b1) : det_ff;
   assign div_num = {cof_abs[mitc_pkg::CMAG_W-1:0], {SH{1'b0}}};

   mitc_div #(
      .NUM_W(NUM_W),
      .DEN_W(mitc_pkg::DMAG_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (dmag_ff),
      .quot (div_quot),
      .sts  (div_sts)
   );

   // Round half away from zero on the magnitude, then clip.
   always_comb begin
      q_inc   = {1'b0, div_quot} + {{NUM_W{1'b0}}, 1'b1};
      q_half  = q_inc[NUM_W:1];
      res_big = |q_half[NUM_W-1:32];
      res_neg = cneg_ff ^ dneg_ff;
      if (res_neg) begin
         res_sat = res_big || (q_half[31:0] > 32'h8000_0000);
         res_val = res_sat ? 32'h8000_0000 : (~q_half[31:0] + 32'd1);
      end else begin
         res_sat = res_big || q_half[31];
         res_val = res_sat ? 32'h7FFF_FFFF : q_half[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mitc_pkg::ST_LOAD;
         ph_ff       <= '0;
         term_ff     <= '0;
         idx_ff      <= '0;
         load_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         ph_ff       <= ph_in;
         term_ff     <= term_in;
         idx_ff      <= idx_in;
         load_cnt_ff <= load_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ph_in       = ph_ff;
      term_in     = term_ff;
      idx_in      = idx_ff;
      load_cnt_in = load_cnt_ff;
      div_start   = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         mitc_pkg::ST_LOAD: begin
            if (req_accept) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  state_in = mitc_pkg::ST_COF;
                  ph_in    = '0;
                  term_in  = '0;
                  idx_in   = '0;
               end
            end
         end
         mitc_pkg::ST_COF: begin
            if (ph_ff == 3'd6) begin
               ph_in = '0;
               if (term_ff == 3'd5) begin
                  term_in = '0;
                  idx_in  = idx_ff + 4'd1;
                  if (idx_ff == 4'd15) state_in = mitc_pkg::ST_DET;
               end else begin
                  term_in = term_ff + 3'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         mitc_pkg::ST_DET: begin
            if (ph_ff == 3'd5) begin
               ph_in = '0;
               if (idx_ff == 4'd3) begin
                  idx_in   = '0;
                  state_in = mitc_pkg::ST_CHECK;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         mitc_pkg::ST_CHECK: begin
            if (det_ff == '0) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = mitc_pkg::ST_LOAD;
               end
            end else begin
               state_in = mitc_pkg::ST_DIV_START;
            end
         end
         mitc_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = mitc_pkg::ST_DIV_WAIT;
         end
         mitc_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) state_in = mitc_pkg::ST_EMIT;
         end
         mitc_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff + 4'd1;
               state_in = (idx_ff == 4'd15) ? mitc_pkg::ST_LOAD : mitc_pkg::ST_DIV_START;
            end
         end
         default: state_in = mitc_pkg::ST_LOAD;
      endcase
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) store_ff[load_cnt_ff] <= req_value;
      if (req_accept && load_cnt_ff == 4'd15) begin
         acc_ff <= '0;
         det_ff <= '0;
      end
      if (state_ff == mitc_pkg::ST_COF) begin
         unique case (ph_ff)
            3'd0: ea_ff <= rd_data;
            3'd1: eb_ff <= rd_data;
            3'd2: begin
               ec_ff <= rd_data;
               mp_ff <= mul_p;
            end
            3'd3: begin
               hi_ff <= mp_ff[63:32];
               mp_ff <= mul_p;
            end
            3'd4: begin
               t_ff  <= {64'd0, mp_ff};
               mp_ff <= mul_p;
            end
            3'd5: t_ff <= t_ff + {32'd0, mp_ff, 32'd0};
            3'd6: begin
               if (term_ff == 3'd5) begin
                  cof_ff[idx_ff] <= acc_new;
                  acc_ff         <= '0;
               end else begin
                  acc_ff <= acc_new;
               end
            end
            default: acc_ff <= acc_ff;
         endcase
      end
      if (state_ff == mitc_pkg::ST_DET) begin
         unique case (ph_ff)
            3'd0: begin
               ea_ff   <= rd_data;
               cm_ff   <= cof_abs[mitc_pkg::CMAG_W-1:0];
               cneg_ff <= cof_rd[mitc_pkg::COF_W-1];
            end
            3'd1: mp_ff <= mul_p;
            3'd2: begin
               t_ff  <= {64'd0, mp_ff};
               mp_ff <= mul_p;
            end
            3'd3: begin
               t_ff  <= t_ff + {32'd0, mp_ff, 32'd0};
               mp_ff <= mul_p;
            end
            3'd4: t_ff <= t_ff + {mp_ff, 64'd0};
            3'd5: det_ff <= (ea_ff[31] ^ cneg_ff) ? (det_ff - {3'd0, t_ff})
                                                  : (det_ff + {3'd0, t_ff});
            default: det_ff <= det_ff;
         endcase
      end
      if (state_ff == mitc_pkg::ST_CHECK) begin
         dmag_ff <= det_abs[mitc_pkg::DMAG_W-1:0];
         dneg_ff <= det_ff[mitc_pkg::DET_W-1];
      end
      if (div_start) cneg_ff <= cof_rd[mitc_pkg::COF_W-1];
   end

   // Output register: hold while stalled, load when free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == mitc_pkg::ST_CHECK) begin
            rsp_value_ff     <= '0;
            rsp_singular_ff  <= 1'b1;
            rsp_saturated_ff <= 1'b0;
            rsp_last_ff      <= 1'b1;
         end else begin
            rsp_value_ff     <= res_val;
            rsp_singular_ff  <= 1'b0;
            rsp_saturated_ff <= res_sat;
            rsp_last_ff      <= (idx_ff == 4'd15);
         end
      end
   end

   assign req_stall     = (state_ff != mitc_pkg::ST_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_singular  = rsp_singular_ff;
   assign rsp_saturated = rsp_saturated_ff;
   assign rsp_last      = rsp_last_ff;

   `ASSERT_IMPLY(a_sing_last, clock, reset, rsp_valid && rsp_singular,
                 rsp_last && !rsp_saturated && rsp_value_out == 32'sd0)
   `ASSERT_NEXT(a_load_done, clock, reset,
                req_valid && !req_stall && load_cnt_ff == 4'd15, req_stall)
   `ASSERT_IMPLY(a_div_state, clock, reset, div_sts.busy,
                 state_ff == mitc_pkg::ST_DIV_WAIT)
   `ASSERT_IMPLY(a_emit_free, clock, reset, out_load, !rsp_valid_ff || !rsp_stall)

endmodule
